// File: hdl/vbtp_pkg.sv
package vbtp_pkg;

    localparam int ACT_W      = 2;
    localparam int COORD_W    = 6;
    localparam int CENTER_W   = 12;
    localparam int RADIUS_W   = 11;
    localparam int COUNT_W    = 19;
    localparam int STATUS_W   = 2;
    localparam int SIZE_W     = 7;
    localparam int PCT_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int PCT_SCALE  = 100;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;
    localparam logic [PCT_W-1:0]  PCT_RESET  = 7'd80;

    typedef enum logic [ACT_W-1:0] {
        ACT_WRITE = 2'd0,
        ACT_TEST  = 2'd1,
        ACT_PAINT = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_OUTSIDE = 2'd1,
        ST_EMPTY   = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIZE_X  = 2'd0,
        CFG_SIZE_Y  = 2'd1,
        CFG_SIZE_Z  = 2'd2,
        CFG_MIN_PCT = 2'd3
    } t_cfg_idx;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_ready;
        logic load;
        logic bnd;
        logic sq0;
        logic sqz;
        logic sqy;
        logic row;
        logic walk;
        logic next;
        logic wrd;
        logic wwr;
        logic clr;
        logic mul;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic    in_valid;
        t_action act;
        logic    walk_ok;
        logic    write_ok;
        logic    x_last;
        logic    row_last;
        logic    slab_last;
        logic    clr_last;
        logic    out_busy;
    } t_stat;

endpackage

// File: hdl/vbtp_if.sv
interface vbtp_in_if import vbtp_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [ACT_W-1:0]           action;
    logic [COORD_W-1:0]         voxel_x;
    logic [COORD_W-1:0]         voxel_y;
    logic [COORD_W-1:0]         voxel_z;
    logic                       voxel_value;
    logic signed [CENTER_W-1:0] center_x;
    logic signed [CENTER_W-1:0] center_y;
    logic signed [CENTER_W-1:0] center_z;
    logic [RADIUS_W-1:0]        radius;

    modport source (
        output valid, action, voxel_x, voxel_y, voxel_z, voxel_value,
               center_x, center_y, center_z, radius,
        input  ready
    );
    modport sink (
        input  valid, action, voxel_x, voxel_y, voxel_z, voxel_value,
               center_x, center_y, center_z, radius,
        output ready
    );
endinterface

interface vbtp_out_if import vbtp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [COUNT_W-1:0]  shape_count;
    logic [COUNT_W-1:0]  background_count;
    logic                accepted;
    logic [COUNT_W-1:0]  painted_count;
    logic [STATUS_W-1:0] status;

    modport source (
        output valid, shape_count, background_count, accepted, painted_count, status,
        input  ready
    );
    modport sink (
        input  valid, shape_count, background_count, accepted, painted_count, status,
        output ready
    );
endinterface

interface vbtp_cfg_if import vbtp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [SIZE_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/voxel_ball_test_and_paint.sv
// Channel  Role    Handshake    Carries
// i_in     sink    valid/ready  action, voxel_x/y/z, voxel_value, center_x/y/z, radius
// o_out    source  valid/ready  shape_count, background_count, accepted, painted_count, status
// i_cfg    sink    valid/ready  index, data (always ready)
//
// One request is worked on at a time. A voxel write reads its row and then writes it back.
// A ball walks the clipped bounding box row by row: the volume memory returns one x row per
// read, and the walk compares one voxel per cycle along that row.
// After reset a clearing pass writes every row of the volume to background,
// before the first request is taken.
// A finished result waits in the output register while the next request runs.
module voxel_ball_test_and_paint import vbtp_pkg::*; #(
    parameter int MAX_DIM   = 64,
    parameter int FRAC_BITS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vbtp_in_if.sink     i_in,
    vbtp_out_if.source  o_out,
    vbtp_cfg_if.sink    i_cfg
);

    t_cmd  w_cmd;
    t_stat w_stat;

    vbtp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    vbtp_dpath #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cfg   (i_cfg),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat)
    );

endmodule

// File: hdl/vbtp_ctrl.sv
module vbtp_ctrl import vbtp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [12:0] {
        S_CLR  = 13'b0000000000001,
        S_IDLE = 13'b0000000000010,
        S_BND  = 13'b0000000000100,
        S_SQ0  = 13'b0000000001000,
        S_SQZ  = 13'b0000000010000,
        S_SQY  = 13'b0000000100000,
        S_ROW  = 13'b0000001000000,
        S_WALK = 13'b0000010000000,
        S_NEXT = 13'b0000100000000,
        S_WRD  = 13'b0001000000000,
        S_WWR  = 13'b0010000000000,
        S_MUL  = 13'b0100000000000,
        S_EMIT = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_stat.in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_BND;
                end
            end
            S_BND: begin
                o_cmd.bnd = 1'b1;
                unique case (i_stat.act) inside
                    ACT_WRITE:           n_state = i_stat.write_ok ? S_WRD : S_EMIT;
                    ACT_TEST, ACT_PAINT: n_state = S_SQ0;
                    default:             n_state = S_EMIT;
                endcase
            end
            S_SQ0: begin
                o_cmd.sq0 = 1'b1;
                n_state   = i_stat.walk_ok ? S_SQZ : S_MUL;
            end
            S_SQZ: begin
                o_cmd.sqz = 1'b1;
                n_state   = S_SQY;
            end
            S_SQY: begin
                o_cmd.sqy = 1'b1;
                n_state   = S_ROW;
            end
            S_ROW: begin
                o_cmd.row = 1'b1;
                n_state   = S_WALK;
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_stat.x_last) begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                o_cmd.next = 1'b1;
                if (i_stat.row_last && i_stat.slab_last) begin
                    n_state = S_MUL;
                end else if (i_stat.row_last) begin
                    n_state = S_SQZ;
                end else begin
                    n_state = S_SQY;
                end
            end
            S_WRD: begin
                o_cmd.wrd = 1'b1;
                n_state   = S_WWR;
            end
            S_WWR: begin
                o_cmd.wwr = 1'b1;
                n_state   = S_EMIT;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_load_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> !o_cmd.in_ready)
        else $error("input still ready after a request was taken");

    a_load_to_bnd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_stat.in_valid && o_cmd.in_ready) |=> (r_state == S_BND))
        else $error("accepted request did not start bound computation");

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("controller state is not one-hot");
`endif

endmodule

// File: hdl/vbtp_dpath.sv
module vbtp_dpath import vbtp_pkg::*; #(
    parameter int MAX_DIM   = 64,
    parameter int FRAC_BITS = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    vbtp_in_if.sink           i_in,
    vbtp_out_if.source        o_out,
    vbtp_cfg_if.sink          i_cfg,
    input  t_cmd              i_cmd,
    output t_stat             o_stat
);

    localparam int XW   = $clog2(MAX_DIM);
    localparam int NW   = $clog2(MAX_DIM + 1);
    localparam int RW   = 2 * XW;
    localparam int ROWS = 1 << RW;
    localparam int DW   = (((XW + FRAC_BITS + 1) > CENTER_W) ?
                           (XW + FRAC_BITS + 1) : CENTER_W) + 1;
    localparam int SQW  = 2 * DW;
    localparam int BW   = SQW + 1;
    localparam int SW   = SQW + 2;
    localparam int AW   = ((NW + FRAC_BITS + 1) > 14) ? (NW + FRAC_BITS + 1) : 14;
    localparam int CW   = 3 * XW + 1;
    localparam int PW   = CW + 8;

    typedef struct packed {
        logic          ok;
        logic          enclosed;
        logic [XW-1:0] lo;
        logic [XW-1:0] hi;
    } t_axis;

    // Voxel index range along one axis, clipped to the image, plus the
    // strict containment test used by the ball test.
    function automatic t_axis axis_bounds(input logic signed [CENTER_W-1:0] c,
                                          input logic [RADIUS_W-1:0] r,
                                          input logic [NW-1:0] n);
        logic signed [AW-1:0] a;
        logic signed [AW-1:0] b;
        logic signed [AW-1:0] l;
        logic signed [AW-1:0] h;
        logic signed [AW-1:0] nmax;
        logic signed [AW-1:0] lim;
        t_axis res;
        a    = AW'(c) - AW'(r);
        b    = AW'(c) + AW'(r);
        lim  = AW'(n) << FRAC_BITS;
        nmax = AW'(n);
        nmax = nmax - AW'(1);
        l    = (a <= 0) ? '0 : ((a + AW'((1 << FRAC_BITS) - 1)) >>> FRAC_BITS);
        h    = b >>> FRAC_BITS;
        if (h > nmax) begin
            h = nmax;
        end
        res.ok       = (b >= 0) && (n != '0) && (l <= h);
        res.enclosed = (a >= 0) && (b < lim);
        res.lo       = XW'(l);
        res.hi       = XW'(h);
        return res;
    endfunction

    function automatic logic signed [DW-1:0] axis_delta(input logic signed [CENTER_W-1:0] c,
                                                        input logic [XW-1:0] p);
        logic signed [DW-1:0] ps;
        ps = DW'(p) << FRAC_BITS;
        return DW'(c) - ps;
    endfunction

    // Configuration
    logic [SIZE_W-1:0] r_size_x, r_size_y, r_size_z;
    logic [PCT_W-1:0]  r_min_pct;
    logic [NW-1:0]     w_nx, w_ny, w_nz;

    // Request
    t_action                    r_act;
    logic [COORD_W-1:0]         r_vx, r_vy, r_vz;
    logic                       r_val;
    logic signed [CENTER_W-1:0] r_cx, r_cy, r_cz;
    logic [RADIUS_W-1:0]        r_rad;

    // Walk
    t_axis                r_ax, r_ay, r_az;
    logic [SQW-1:0]       r_r2, r_dx2_0, r_dz2, r_dy2, r_dx2;
    logic signed [DW-1:0] r_dx0, r_dx;
    logic [BW-1:0]        r_base;
    logic [XW-1:0]        r_i, r_j, r_k;
    logic [CW-1:0]        r_shape, r_back, r_paint;
    logic [PW-1:0]        r_prod_a, r_prod_b;
    logic [RW-1:0]        r_clr;

    // Volume memory, one word per (z, y) row
    logic [MAX_DIM-1:0] r_mem [ROWS];
    logic [MAX_DIM-1:0] r_row;

    // Result
    logic               r_out_valid;
    logic [COUNT_W-1:0] r_o_shape, r_o_back, r_o_paint;
    logic               r_o_acc;
    t_status            r_o_status;

    logic signed [DW-1:0]  w_dx0, w_dy, w_dz, w_sq_in;
    logic signed [SQW-1:0] w_sq;
    logic signed [SW-1:0]  w_dx_ext, w_dx2_s;
    logic                  w_in_ball, w_inside, w_write_ok, w_hit;
    logic [CW-1:0]         w_total;
    logic                  w_mem_we, w_rd;
    logic [RW-1:0]         w_mem_waddr, w_raddr, w_vaddr, w_baddr;
    logic [MAX_DIM-1:0]    w_mem_wdata, w_wr_row;
    t_status               w_status;
    logic                  w_acc;

    assign w_nx = (int'(r_size_x) > MAX_DIM) ? NW'(MAX_DIM) : NW'(r_size_x);
    assign w_ny = (int'(r_size_y) > MAX_DIM) ? NW'(MAX_DIM) : NW'(r_size_y);
    assign w_nz = (int'(r_size_z) > MAX_DIM) ? NW'(MAX_DIM) : NW'(r_size_z);

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x  <= SIZE_RESET;
            r_size_y  <= SIZE_RESET;
            r_size_z  <= SIZE_RESET;
            r_min_pct <= PCT_RESET;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_SIZE_X:  r_size_x  <= i_cfg.data;
                CFG_SIZE_Y:  r_size_y  <= i_cfg.data;
                CFG_SIZE_Z:  r_size_z  <= i_cfg.data;
                CFG_MIN_PCT: r_min_pct <= i_cfg.data;
            endcase
        end
    end

    assign i_in.ready = i_cmd.in_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act <= t_action'(i_in.action);
            r_vx  <= i_in.voxel_x;
            r_vy  <= i_in.voxel_y;
            r_vz  <= i_in.voxel_z;
            r_val <= i_in.voxel_value;
            r_cx  <= i_in.center_x;
            r_cy  <= i_in.center_y;
            r_cz  <= i_in.center_z;
            r_rad <= i_in.radius;
        end
    end

    // One shared squarer serves r^2 and the per-axis distance squares.
    assign w_dx0 = axis_delta(r_cx, r_ax.lo);
    assign w_dy  = axis_delta(r_cy, r_j);
    assign w_dz  = axis_delta(r_cz, r_k);

    always_comb begin
        if (i_cmd.bnd) begin
            w_sq_in = DW'(r_rad);
        end else if (i_cmd.sq0) begin
            w_sq_in = w_dx0;
        end else if (i_cmd.sqz) begin
            w_sq_in = w_dz;
        end else begin
            w_sq_in = w_dy;
        end
    end

    assign w_sq = SQW'(w_sq_in) * SQW'(w_sq_in);

    // Stepping x by one voxel: (d - s)^2 = d^2 - 2*s*d + s^2 with s = 2^F.
    assign w_dx_ext = SW'(r_dx);
    assign w_dx2_s  = signed'(SW'(r_dx2)) - (w_dx_ext <<< (FRAC_BITS + 1))
                      + (SW'(1) <<< (2 * FRAC_BITS));

    assign w_in_ball = (SW'(r_base) + SW'(r_dx2)) <= SW'(r_r2);
    assign w_hit     = i_cmd.walk && w_in_ball;
    assign w_inside  = r_ax.enclosed && r_ay.enclosed && r_az.enclosed;
    assign w_total   = r_shape + r_back;

    assign w_write_ok = (int'(r_vx) < int'(w_nx)) && (int'(r_vy) < int'(w_ny))
                        && (int'(r_vz) < int'(w_nz));

    always_ff @(posedge i_clk) begin
        if (i_cmd.bnd) begin
            r_ax <= axis_bounds(r_cx, r_rad, w_nx);
            r_ay <= axis_bounds(r_cy, r_rad, w_ny);
            r_az <= axis_bounds(r_cz, r_rad, w_nz);
            r_r2 <= w_sq;
        end
        if (i_cmd.sq0) begin
            r_dx0   <= w_dx0;
            r_dx2_0 <= w_sq;
            r_j     <= r_ay.lo;
            r_k     <= r_az.lo;
        end
        if (i_cmd.sqz) begin
            r_dz2 <= w_sq;
        end
        if (i_cmd.sqy) begin
            r_dy2 <= w_sq;
        end
        if (i_cmd.row) begin
            r_base <= BW'(r_dz2) + BW'(r_dy2);
            r_i    <= r_ax.lo;
            r_dx   <= r_dx0;
            r_dx2  <= r_dx2_0;
        end
        if (i_cmd.walk) begin
            r_i   <= r_i + XW'(1);
            r_dx  <= r_dx - DW'(1 << FRAC_BITS);
            r_dx2 <= SQW'(w_dx2_s);
        end
        if (i_cmd.next) begin
            if (r_j == r_ay.hi) begin
                r_j <= r_ay.lo;
                r_k <= r_k + XW'(1);
            end else begin
                r_j <= r_j + XW'(1);
            end
        end
        if (i_cmd.mul) begin
            r_prod_a <= PW'(r_shape) * PW'(PCT_SCALE);
            r_prod_b <= PW'(r_min_pct) * PW'(w_total);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_shape <= '0;
            r_back  <= '0;
            r_paint <= '0;
        end else if (w_hit) begin
            if (r_act == ACT_PAINT) begin
                r_paint <= r_paint + CW'(1);
            end else if (r_row[r_i]) begin
                r_back <= r_back + CW'(1);
            end else begin
                r_shape <= r_shape + CW'(1);
            end
        end
    end

    // Memory port control
    assign w_vaddr = {XW'(r_vz), XW'(r_vy)};
    assign w_baddr = {r_k, r_j};
    assign w_rd    = i_cmd.sqy || i_cmd.wrd;
    assign w_raddr = i_cmd.wrd ? w_vaddr : w_baddr;

    always_comb begin
        w_wr_row = r_row;
        w_wr_row[XW'(r_vx)] = r_val;
    end

    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_waddr = w_baddr;
        w_mem_wdata = r_row;
        if (i_cmd.clr) begin
            w_mem_we    = 1'b1;
            w_mem_waddr = r_clr;
            w_mem_wdata = '1;
        end else if (i_cmd.wwr) begin
            w_mem_we    = 1'b1;
            w_mem_waddr = w_vaddr;
            w_mem_wdata = w_wr_row;
        end else if (i_cmd.next && (r_act == ACT_PAINT)) begin
            w_mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd) begin
            r_row <= r_mem[w_raddr];
        end else if (w_hit && (r_act == ACT_PAINT)) begin
            r_row[r_i] <= r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr) begin
            r_clr <= r_clr + RW'(1);
        end
    end

    // Result
    always_comb begin
        w_status = ST_OK;
        w_acc    = 1'b0;
        if (r_act == ACT_TEST) begin
            if (!w_inside) begin
                w_status = ST_OUTSIDE;
            end else if (w_total == '0) begin
                w_status = ST_EMPTY;
            end else begin
                w_acc = (r_prod_a >= r_prod_b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_shape  <= COUNT_W'(r_shape);
            r_o_back   <= COUNT_W'(r_back);
            r_o_paint  <= COUNT_W'(r_paint);
            r_o_acc    <= w_acc;
            r_o_status <= w_status;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.shape_count      = r_o_shape;
    assign o_out.background_count = r_o_back;
    assign o_out.accepted         = r_o_acc;
    assign o_out.painted_count    = r_o_paint;
    assign o_out.status           = r_o_status;

    always_comb begin
        o_stat.in_valid  = i_in.valid;
        o_stat.act       = r_act;
        o_stat.walk_ok   = r_ax.ok && r_ay.ok && r_az.ok
                           && ((r_act == ACT_PAINT) || w_inside);
        o_stat.write_ok  = w_write_ok;
        o_stat.x_last    = (r_i == r_ax.hi);
        o_stat.row_last  = (r_j == r_ay.hi);
        o_stat.slab_last = (r_k == r_az.hi);
        o_stat.clr_last  = &r_clr;
        o_stat.out_busy  = r_out_valid && !o_out.ready;
    end

`ifndef SYNTHESIS
    a_walk_in_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.walk |-> (r_i >= r_ax.lo) && (r_i <= r_ax.hi))
        else $error("x index left the bounding box during a row walk");

    a_row_in_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sqy |-> (r_j <= r_ay.hi) && (r_k <= r_az.hi))
        else $error("row address left the bounding box");

    a_paint_no_test_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.mul && (r_act == ACT_PAINT)) |-> (r_shape == '0) && (r_back == '0))
        else $error("paint request accumulated test counts");
`endif

endmodule

// File: tb/sv/voxel_ball_test_and_paint_test.sv
`timescale 1ns / 1ps

module voxel_ball_test_and_paint_test;
    import vbtp_pkg::*;

    localparam int VOL_DIM     = 64;
    localparam int FRAC        = 4;
    localparam int ONE         = 1 << FRAC;
    localparam int QUIET_LIMIT = 1_000_000;
    localparam int LONG_HOLD   = 400;

    typedef struct {
        t_action                    act;
        logic [COORD_W-1:0]         vx;
        logic [COORD_W-1:0]         vy;
        logic [COORD_W-1:0]         vz;
        logic                       val;
        logic signed [CENTER_W-1:0] cx;
        logic signed [CENTER_W-1:0] cy;
        logic signed [CENTER_W-1:0] cz;
        logic [RADIUS_W-1:0]        rad;
    } t_voxel_req;

    typedef struct {
        logic [COUNT_W-1:0] shape_cnt;
        logic [COUNT_W-1:0] back_cnt;
        logic               accepted;
        logic [COUNT_W-1:0] painted_cnt;
        t_status            status;
    } t_ball_result;

    logic i_clk;
    logic i_rst_n;

    vbtp_in_if  in_if ();
    vbtp_out_if out_if ();
    vbtp_cfg_if cfg_if ();

    voxel_ball_test_and_paint u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Local copy of the volume and of the registers.
    bit               vol_bits [0:VOL_DIM*VOL_DIM*VOL_DIM-1];
    logic [SIZE_W-1:0] ext_x, ext_y, ext_z;
    logic [PCT_W-1:0]  min_pct;

    t_voxel_req   pending_reqs [$];
    t_ball_result due_replies [$];
    t_voxel_req   cur_req;

    int  pushed_count   = 0;
    int  accepted_count = 0;
    int  results_seen   = 0;
    int  error_count    = 0;
    int  tx_gap         = 0;
    int  rx_stall       = 0;
    int  quiet_cycles   = 0;
    bit  long_hold_done = 0;
    bit  steady_flow    = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int eff_extent(logic [SIZE_W-1:0] s);
        return (s > VOL_DIM) ? VOL_DIM : int'(s);
    endfunction

    function automatic int vol_index(int x, int y, int z);
        return (z * VOL_DIM + y) * VOL_DIM + x;
    endfunction

    // Voxel index range along one axis that can hold ball voxels, clipped to the image.
    function automatic bit axis_span(input int c, input int r, input int n,
                                     output int lo, output int hi);
        int a, b;
        a  = c - r;
        b  = c + r;
        lo = 0;
        hi = -1;
        if (b < 0 || n == 0) return 0;
        lo = (a <= 0) ? 0 : (a + ONE - 1) / ONE;
        hi = b / ONE;
        if (hi > n - 1) hi = n - 1;
        return lo <= hi;
    endfunction

    function automatic bit fits_axis(int c, int r, int n);
        return (c - r >= 0) && (c + r < n * ONE);
    endfunction

    // Applies one request to the local volume and returns the reply it must produce.
    function automatic t_ball_result apply_request(t_voxel_req q);
        t_ball_result res;
        int nx, ny, nz, cx, cy, cz, rad, r2;
        int x0, x1, y0, y1, z0, z1, dx, dy, dz, idx;
        int shp, bgd, pnt;
        bit has_box;
        nx  = eff_extent(ext_x);
        ny  = eff_extent(ext_y);
        nz  = eff_extent(ext_z);
        cx  = q.cx;
        cy  = q.cy;
        cz  = q.cz;
        rad = q.rad;
        r2  = rad * rad;
        shp = 0;
        bgd = 0;
        pnt = 0;
        res.shape_cnt   = '0;
        res.back_cnt    = '0;
        res.accepted    = 1'b0;
        res.painted_cnt = '0;
        res.status      = ST_OK;
        case (q.act) inside
            ACT_WRITE: begin
                if (q.vx < nx && q.vy < ny && q.vz < nz)
                    vol_bits[vol_index(q.vx, q.vy, q.vz)] = q.val;
            end
            ACT_TEST, ACT_PAINT: begin
                if (q.act == ACT_TEST &&
                    !(fits_axis(cx, rad, nx) && fits_axis(cy, rad, ny) &&
                      fits_axis(cz, rad, nz))) begin
                    res.status = ST_OUTSIDE;
                end else begin
                    has_box = axis_span(cx, rad, nx, x0, x1) &&
                              axis_span(cy, rad, ny, y0, y1) &&
                              axis_span(cz, rad, nz, z0, z1);
                    if (has_box) begin
                        for (int k = z0; k <= z1; k++) begin
                            for (int j = y0; j <= y1; j++) begin
                                for (int i = x0; i <= x1; i++) begin
                                    dx = cx - i * ONE;
                                    dy = cy - j * ONE;
                                    dz = cz - k * ONE;
                                    if (dx * dx + dy * dy + dz * dz <= r2) begin
                                        idx = vol_index(i, j, k);
                                        if (q.act == ACT_PAINT) begin
                                            vol_bits[idx] = q.val;
                                            pnt++;
                                        end else if (vol_bits[idx]) begin
                                            bgd++;
                                        end else begin
                                            shp++;
                                        end
                                    end
                                end
                            end
                        end
                    end
                    if (q.act == ACT_PAINT) begin
                        res.painted_cnt = pnt[COUNT_W-1:0];
                    end else begin
                        res.shape_cnt = shp[COUNT_W-1:0];
                        res.back_cnt  = bgd[COUNT_W-1:0];
                        if (shp + bgd == 0)
                            res.status = ST_EMPTY;
                        else if (longint'(PCT_SCALE) * shp >= longint'(min_pct) * (shp + bgd))
                            res.accepted = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady_flow || roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(30, 90);
    endfunction

    task automatic report_error(string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_error($sformatf("reply %0d: %s is %0d, expected %0d",
                                   results_seen, name, got, want));
    endtask

    task automatic check_reply();
        t_ball_result want;
        results_seen++;
        if (due_replies.size() == 0) begin
            report_error($sformatf("reply %0d arrived with no request outstanding",
                                   results_seen));
            return;
        end
        want = due_replies.pop_front();
        compare_field("shape_count", out_if.shape_count, want.shape_cnt);
        compare_field("background_count", out_if.background_count, want.back_cnt);
        compare_field("accepted", out_if.accepted, want.accepted);
        compare_field("painted_count", out_if.painted_count, want.painted_cnt);
        compare_field("status", out_if.status, want.status);
    endtask

    // Request driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                due_replies.push_back(apply_request(cur_req));
                accepted_count++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    in_if.valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    cur_req = pending_reqs.pop_front();
                    in_if.action      <= cur_req.act;
                    in_if.voxel_x     <= cur_req.vx;
                    in_if.voxel_y     <= cur_req.vy;
                    in_if.voxel_z     <= cur_req.vz;
                    in_if.voxel_value <= cur_req.val;
                    in_if.center_x    <= cur_req.cx;
                    in_if.center_y    <= cur_req.cy;
                    in_if.center_z    <= cur_req.cz;
                    in_if.radius      <= cur_req.rad;
                    in_if.valid       <= 1'b1;
                    tx_gap = pick_gap();
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Reply monitor. Once, it refuses replies for a long stretch so that the
    // block fills up and has to hold off new requests.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (out_if.valid && out_if.ready) check_reply();
            if (rx_stall > 0) begin
                rx_stall--;
                out_if.ready <= 1'b0;
            end else if (!long_hold_done && results_seen >= 30) begin
                long_hold_done = 1;
                rx_stall = LONG_HOLD;
                out_if.ready <= 1'b0;
            end else if (!steady_flow && $urandom_range(0, 5) == 0) begin
                rx_stall = pick_gap();
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("voxel_ball_test_and_paint_test NOT OK");
            $finish;
        end
    end

    function automatic t_voxel_req random_req(t_action a);
        t_voxel_req q;
        q.act = a;
        q.vx  = $urandom_range(0, 63);
        q.vy  = $urandom_range(0, 63);
        q.vz  = $urandom_range(0, 63);
        q.val = $urandom_range(0, 1);
        q.cx  = $urandom_range(0, 4095);
        q.cy  = $urandom_range(0, 4095);
        q.cz  = $urandom_range(0, 4095);
        q.rad = $urandom_range(0, 63);
        return q;
    endfunction

    function automatic t_voxel_req ball_req(t_action a, int cx, int cy, int cz, int rad, bit val);
        t_voxel_req q;
        q     = random_req(a);
        q.cx  = cx;
        q.cy  = cy;
        q.cz  = cz;
        q.rad = rad;
        q.val = val;
        return q;
    endfunction

    function automatic t_voxel_req voxel_write(int x, int y, int z, bit val);
        t_voxel_req q;
        q     = random_req(ACT_WRITE);
        q.vx  = x;
        q.vy  = y;
        q.vz  = z;
        q.val = val;
        return q;
    endfunction

    task automatic queue_req(t_voxel_req q);
        pending_reqs.push_back(q);
        pushed_count++;
    endtask

    task automatic drain();
        while (accepted_count != pushed_count || due_replies.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_register(t_cfg_idx idx, logic [SIZE_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            CFG_SIZE_X:  ext_x   = val;
            CFG_SIZE_Y:  ext_y   = val;
            CFG_SIZE_Z:  ext_z   = val;
            CFG_MIN_PCT: min_pct = val;
            default: ;
        endcase
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic int pick_center(logic [SIZE_W-1:0] ext);
        int n;
        n = eff_extent(ext);
        return (n > 0 ? int'($urandom_range(0, n - 1)) : 0) * ONE + $urandom_range(0, ONE - 1);
    endfunction

    // A group of requests around one spot, mixed in random order: writes and paints shape
    // the volume, tests look at what was built, and some fully random requests come in too.
    task automatic add_cluster(int n_items);
        int cx, cy, cz, pick;
        cx = pick_center(ext_x);
        cy = pick_center(ext_y);
        cz = pick_center(ext_z);
        repeat (n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                queue_req(random_req(t_action'($urandom_range(0, 3))));
            else if (pick < 35)
                queue_req(voxel_write(cx / ONE + int'($urandom_range(0, 4)) - 2,
                                      cy / ONE + int'($urandom_range(0, 4)) - 2,
                                      cz / ONE + int'($urandom_range(0, 4)) - 2,
                                      $urandom_range(0, 1)));
            else if (pick < 55)
                queue_req(ball_req(ACT_PAINT, cx + int'($urandom_range(0, 16)) - 8,
                                   cy + int'($urandom_range(0, 16)) - 8,
                                   cz + int'($urandom_range(0, 16)) - 8,
                                   $urandom_range(0, 40), $urandom_range(0, 3) == 0));
            else
                queue_req(ball_req(ACT_TEST, cx + int'($urandom_range(0, 8)) - 4,
                                   cy + int'($urandom_range(0, 8)) - 4,
                                   cz + int'($urandom_range(0, 8)) - 4,
                                   $urandom_range(0, 40), 1'b0));
        end
    endtask

    task automatic run_phase(int sx, int sy, int sz, int pct, bit steady);
        set_register(CFG_SIZE_X, sx);
        set_register(CFG_SIZE_Y, sy);
        set_register(CFG_SIZE_Z, sz);
        set_register(CFG_MIN_PCT, pct);
        steady_flow = steady;
        repeat (3) add_cluster(6);
        drain();
        steady_flow = 0;
    endtask

    initial begin
        foreach (vol_bits[i]) vol_bits[i] = 1'b1;
        ext_x   = SIZE_RESET;
        ext_y   = SIZE_RESET;
        ext_z   = SIZE_RESET;
        min_pct = PCT_RESET;

        i_rst_n           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.action      = ACT_WRITE;
        in_if.voxel_x     = '0;
        in_if.voxel_y     = '0;
        in_if.voxel_z     = '0;
        in_if.voxel_value = 1'b0;
        in_if.center_x    = '0;
        in_if.center_y    = '0;
        in_if.center_z    = '0;
        in_if.radius      = '0;
        out_if.ready      = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = CFG_SIZE_X;
        cfg_if.data       = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests on the full 64 cube with the reset threshold.
        queue_req(ball_req(ACT_TEST, 512, 512, 512, 40, 1'b0));
        queue_req(voxel_write(0, 0, 0, 1'b0));
        queue_req(voxel_write(63, 63, 63, 1'b0));
        queue_req(voxel_write(63, 0, 63, 1'b1));
        queue_req(ball_req(ACT_TEST, 0, 0, 0, 0, 1'b0));
        queue_req(ball_req(ACT_TEST, 8, 8, 8, 0, 1'b0));
        queue_req(ball_req(ACT_TEST, 0, 0, 0, 16, 1'b0));
        queue_req(ball_req(ACT_TEST, 1008, 1008, 1008, 15, 1'b0));
        queue_req(ball_req(ACT_TEST, 1009, 1009, 1009, 15, 1'b0));
        queue_req(ball_req(ACT_TEST, 1000, 1000, 1000, 23, 1'b0));
        queue_req(ball_req(ACT_TEST, 2047, 2047, 2047, 0, 1'b0));
        queue_req(ball_req(ACT_TEST, -2048, -2048, -2048, 0, 1'b0));
        queue_req(ball_req(ACT_PAINT, -2048, -2048, -2048, 2047, 1'b0));
        queue_req(ball_req(ACT_PAINT, 2047, 2047, 2047, 0, 1'b0));
        queue_req(random_req(ACT_NONE));
        // The largest radius paints every voxel of the image.
        queue_req(ball_req(ACT_PAINT, 512, 512, 512, 2047, 1'b0));
        queue_req(ball_req(ACT_TEST, 512, 512, 512, 64, 1'b0));
        queue_req(ball_req(ACT_PAINT, 100, 100, 100, 30, 1'b1));
        queue_req(ball_req(ACT_TEST, 100, 100, 100, 40, 1'b0));
        queue_req(voxel_write(32, 32, 32, 1'b1));
        queue_req(ball_req(ACT_TEST, 512, 512, 512, 20, 1'b0));
        queue_req(random_req(ACT_NONE));
        drain();

        run_phase(8, 8, 8, 50, 1'b1);
        run_phase(12, 5, 16, 100, 1'b0);
        run_phase(0, 9, 9, 30, 1'b0);
        run_phase(127, 1, 100, 127, 1'b0);
        run_phase(1, 1, 1, 0, 1'b0);
        run_phase($urandom_range(1, 24), $urandom_range(1, 24), $urandom_range(1, 24),
                  $urandom_range(0, 100), 1'b0);
        run_phase(64, 64, 64, 101, 1'b0);

        repeat (20) @(posedge i_clk);
        if (error_count == 0)
            $display("voxel_ball_test_and_paint_test OK");
        else
            $display("voxel_ball_test_and_paint_test NOT OK");
        $finish;
    end

endmodule
